### rtl/audio_delay_wet_dry_mix_unit_assert.svh
// assertion macros for the delay line with wet/dry mix
// expects clk and arst_n in the scope where a macro is used
`ifndef AUDIO_DELAY_WET_DRY_MIX_UNIT_ASSERT_SVH
`define AUDIO_DELAY_WET_DRY_MIX_UNIT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define ADM_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent on the next clock edge
`define ADM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/adm_pkg.sv
// shared types and constants of the delay line with wet/dry mix
// no dependencies
`default_nettype none

package adm_pkg;

	localparam int MAX_DELAY   = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(MAX_DELAY);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int WGT_W       = 16;
	localparam int CFG_W       = 16;
	localparam int IDX_W       = 1;
	localparam int MIX_SHIFT   = 15;
	localparam int QDEPTH      = 4;
	localparam int QA_W        = $clog2(QDEPTH);
	localparam int CNT_W       = $clog2(QDEPTH + 1);

	localparam logic [WGT_W-1:0] MIX_ONE = WGT_W'(32768);
	localparam logic [WGT_W-1:0] MIX_RST = WGT_W'(16384);
	localparam logic [SAMPLE_BITS-1:0] SMP_HALF = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// register indexes
	localparam logic [IDX_W-1:0] CFG_DELAY = IDX_W'(0);
	localparam logic [IDX_W-1:0] CFG_WET   = IDX_W'(1);

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [WGT_W-1:0] wgt_t;

	// dry sample and delayed sample of one item
	typedef struct packed {
		smp_t dry;
		smp_t wet;
	} pair_t;

endpackage

`default_nettype wire

### rtl/adm_front.sv
// front end: ring position, history memory and delayed sample lookup
// depends on adm_pkg
`default_nettype none

module adm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire adm_pkg::smp_t sample_in,
	input  wire adm_pkg::len_t len,
	input  wire logic          clear,
	output logic               valid,
	output adm_pkg::pair_t     pair
);
	import adm_pkg::*;

	smp_t              hist_mem [MAX_DELAY];
	logic [ADDR_W-1:0] pos_q;
	logic              wrapped_q;
	logic              valid_s1;
	smp_t              dry_s1;
	smp_t              rd_s1;
	logic              live_s1;
	logic              at_end;

	assign at_end = (LEN_W'(pos_q) + LEN_W'(1)) == len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (clear) begin
				pos_q     <= '0;
				wrapped_q <= 1'b0;
			end else if (accept) begin
				pos_q <= at_end ? '0 : pos_q + ADDR_W'(1);
				if (at_end) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// read-first: the entry returns the sample from one full lap ago
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1           <= hist_mem[pos_q];
			hist_mem[pos_q] <= sample_in;
			dry_s1          <= sample_in;
			live_s1         <= wrapped_q;
		end
	end

	assign valid    = valid_s1;
	assign pair.dry = dry_s1;
	assign pair.wet = live_s1 ? rd_s1 : '0;

endmodule

`default_nettype wire

### rtl/adm_queue.sv
// short queue of sample pairs between front and back
// depends on adm_pkg
`default_nettype none

module adm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire adm_pkg::pair_t din,
	input  wire logic           pop,
	output adm_pkg::pair_t      dout,
	output logic                empty,
	output logic [adm_pkg::CNT_W-1:0] count
);
	import adm_pkg::*;

	pair_t            slot_q [QDEPTH];
	logic [QA_W-1:0]  wr_ptr_q;
	logic [QA_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = slot_q[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

`default_nettype wire

### rtl/adm_back.sv
// back end: weighted blend of dry and delayed samples, result register
// depends on adm_pkg
`default_nettype none

module adm_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire adm_pkg::pair_t in_pair,
	output logic                in_ready,
	input  wire adm_pkg::wgt_t  dry_w,
	input  wire adm_pkg::wgt_t  wet_w,
	output logic                out_valid,
	output adm_pkg::smp_t       out_sample,
	input  wire logic           out_ready
);
	import adm_pkg::*;

	localparam int PROD_W = WGT_W + SAMPLE_BITS;

	logic                   valid_s2;
	logic [PROD_W-1:0]      pdry_s2;
	logic [PROD_W-1:0]      pwet_s2;
	logic                   valid_s3;
	smp_t                   res_s3;
	logic                   ready_s2;
	logic                   ready_s3;
	logic [SAMPLE_BITS-1:0] dry_u;
	logic [SAMPLE_BITS-1:0] wet_u;
	logic [PROD_W:0]        acc;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	// offset binary keeps both products non-negative
	assign dry_u = $unsigned(in_pair.dry) ^ SMP_HALF;
	assign wet_u = $unsigned(in_pair.wet) ^ SMP_HALF;
	assign acc   = (PROD_W + 1)'(pdry_s2) + (PROD_W + 1)'(pwet_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			pdry_s2 <= PROD_W'(dry_w) * PROD_W'(dry_u);
			pwet_s2 <= PROD_W'(wet_w) * PROD_W'(wet_u);
		end
		if (ready_s3 && valid_s2) begin
			res_s3 <= $signed(acc[MIX_SHIFT +: SAMPLE_BITS] ^ SMP_HALF);
		end
	end

	assign out_valid  = valid_s3;
	assign out_sample = res_s3;

endmodule

`default_nettype wire

### rtl/audio_delay_wet_dry_mix_unit.sv
// delay line with wet/dry mix: push to result (empty falls) via front register, queue,
// product and result registers; throughput one item per cycle while pop keeps up, limited
// by the single history memory port pair which does one read and one write per item, and
// by the two multipliers of the back end. reset clears position, pipeline and queue; the
// history reads as zeros until the ring wraps once (a lap flag, no clearing pass); a
// delay_samples write does the same. reset registers: delay_samples 4096, wet_mix 16384
`default_nettype none
`include "audio_delay_wet_dry_mix_unit_assert.svh"

module audio_delay_wet_dry_mix_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input side
	input  wire logic                        push,
	output logic                             full,
	input  wire adm_pkg::smp_t               sample_in,
	// result side
	output logic                             empty,
	input  wire logic                        pop,
	output adm_pkg::smp_t                    sample_out,
	// configuration writes
	input  wire logic                        cfg_we,
	input  wire logic [adm_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [adm_pkg::CFG_W-1:0]   cfg_data
);
	import adm_pkg::*;

	// effective configuration, already clamped
	len_t             len_q;
	wgt_t             wet_w_q;
	wgt_t             dry_w_q;

	logic             accept;
	logic             clear;
	logic             front_valid;
	pair_t            front_pair;
	pair_t            q_head;
	logic             q_empty;
	logic [CNT_W-1:0] q_count;
	logic             q_pop;
	logic             back_ready;
	logic             out_valid;
	len_t             len_wr;
	wgt_t             wet_wr;

	// ---- configuration registers ----
	assign clear  = cfg_we && (cfg_index == CFG_DELAY);
	assign len_wr = cfg_data[LEN_W-1:0];
	// mix above one is fully wet
	assign wet_wr = (cfg_data > MIX_ONE) ? MIX_ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_W'(MAX_DELAY);
			wet_w_q <= MIX_RST;
			dry_w_q <= MIX_ONE - MIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELAY: begin
					// zero delay acts as one, too long acts as the maximum
					if (len_wr == '0) begin
						len_q <= LEN_W'(1);
					end else if (len_wr > LEN_W'(MAX_DELAY)) begin
						len_q <= LEN_W'(MAX_DELAY);
					end else begin
						len_q <= len_wr;
					end
				end
				CFG_WET: begin
					wet_w_q <= wet_wr;
					dry_w_q <= MIX_ONE - wet_wr;
				end
				default: begin
				end
			endcase
		end
	end

	// ---- input side: credit against the queue ----
	// the item sitting in the front register already owns a queue slot
	assign full   = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(front_valid))
	                >= (CNT_W + 1)'(QDEPTH);
	assign accept = push && !full;

	adm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample_in (sample_in),
		.len       (len_q),
		.clear     (clear),
		.valid     (front_valid),
		.pair      (front_pair)
	);

	// ---- decoupling queue ----
	assign q_pop = !q_empty && back_ready;

	adm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.din    (front_pair),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty),
		.count  (q_count)
	);

	// ---- back end: mix and result register ----
	adm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!q_empty),
		.in_pair    (q_head),
		.in_ready   (back_ready),
		.dry_w      (dry_w_q),
		.wet_w      (wet_w_q),
		.out_valid  (out_valid),
		.out_sample (sample_out),
		.out_ready  (pop)
	);

	assign empty = !out_valid;

	// ---- checks ----
	// credit scheme never pushes into a full queue
	`ADM_ASSERT_ALWAYS(a_no_overflow, !front_valid || (q_count < CNT_W'(QDEPTH)) || q_pop, "queue overflow")
	// mix weights always sum to one
	`ADM_ASSERT_ALWAYS(a_weights_sum, (WGT_W + 1)'(wet_w_q) + (WGT_W + 1)'(dry_w_q) == (WGT_W + 1)'(MIX_ONE), "mix weights do not sum to one")
	// an empty front with an empty queue must take an item
	`ADM_ASSERT_ALWAYS(a_no_false_full, front_valid || !q_empty || !full, "full with nothing in flight")
	// an accepted item reaches the queue on the next cycle
	`ADM_ASSERT_NEXT(a_front_to_queue, accept, front_valid, "accepted item lost in front end")

endmodule

`default_nettype wire

### dv/audio_delay_wet_dry_mix_unit_tb.sv
// testbench of the delay line with wet/dry mix: queue handshakes on both sides,
// a self-contained scoreboard that predicts every sample_out from the accepted samples
// depends on adm_pkg and the audio_delay_wet_dry_mix_unit rtl only
module audio_delay_wet_dry_mix_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import adm_pkg::*;

	localparam int LATENCY      = 3;             // drain margin used by settle
	localparam int IDLE_LIMIT   = 2000;          // cycles with no handshake before giving up
	localparam int LAP_LEN      = 64;            // ring length of the lap phase
	localparam int LAP_ITEMS    = LAP_LEN + 40;  // one full lap of that ring and a bit
	localparam int RANDOM_ITEMS = 324;
	localparam int BIG_HOLD     = 80;            // long receiver stall to fill the block
	localparam int HOLD_AT      = 40;            // result count that triggers the long stall

	// ring model of the delay line plus the queue of expected mixed samples
	class delay_mix_scoreboard;
		logic [LEN_W-1:0] delay_reg;
		wgt_t             wet_reg;
		smp_t             ring[MAX_DELAY];
		int unsigned      ring_pos;
		smp_t             expected_out_q[$];
		int               errors;

		function new();
			delay_reg = LEN_W'(MAX_DELAY);
			wet_reg   = MIX_RST;
			errors    = 0;
			clear_ring();
		endfunction

		function void clear_ring();
			foreach (ring[i])
				ring[i] = '0;
			ring_pos = 0;
		endfunction

		// zero acts as one, anything past the store size acts as the store size
		function int unsigned effective_len();
			if (delay_reg == 0)
				return 1;
			if (delay_reg > MAX_DELAY)
				return MAX_DELAY;
			return delay_reg;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_DELAY) begin
				delay_reg = data[LEN_W-1:0];
				clear_ring();
			end else if (idx == CFG_WET) begin
				wet_reg = data;
			end
		endfunction

		// convex blend, floor of the signed sum
		function smp_t mixed_sample(smp_t dry, smp_t wet);
			longint w;
			longint acc;
			w = (wet_reg > MIX_ONE) ? longint'(MIX_ONE) : longint'(wet_reg);
			acc = (longint'(MIX_ONE) - w) * longint'(dry) + w * longint'(wet);
			return smp_t'(acc >>> MIX_SHIFT);
		endfunction

		function void take_sample(smp_t s);
			int unsigned len;
			smp_t old;
			len = effective_len();
			if (ring_pos >= len)
				ring_pos = 0;
			old = ring[ring_pos];
			ring[ring_pos] = s;
			ring_pos++;
			if (ring_pos >= len)
				ring_pos = 0;
			expected_out_q.push_back(mixed_sample(s, old));
		endfunction

		function void check_sample_out(smp_t got);
			smp_t exp_s;
			if (expected_out_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			exp_s = expected_out_q.pop_front();
			if (got !== exp_s) begin
				$display("%0t ns: sample_out mismatch, expected %0d, actual %0d",
					$time, exp_s, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_out_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             push;
	logic             full;
	smp_t             sample_in;
	logic             empty;
	logic             pop;
	smp_t             sample_out;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	delay_mix_scoreboard sb = new();

	bit steady = 1'b0;   // stretch with no idling on either side
	int results_seen = 0;

	audio_delay_wet_dry_mix_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	function int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// full range most of the time, plus small values and the rails
	function smp_t rand_sample();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 70)
			return smp_t'($urandom);
		if (r < 85) begin
			v = int'($urandom_range(0, 200)) - 100;
			return smp_t'(v);
		end
		case ($urandom_range(0, 3))
			0: return smp_t'(16'h8000);
			1: return smp_t'(16'h7fff);
			2: return smp_t'(16'hffff);
			default: return smp_t'(16'h0000);
		endcase
	endfunction

	// short delays dominate so the ring wraps often; some codes exercise the masking
	function logic [CFG_W-1:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return CFG_W'($urandom_range(1, 8));
		if (r < 75)
			return CFG_W'($urandom_range(9, 64));
		if (r < 83)
			return '0;
		if (r < 90)
			return CFG_W'($urandom_range(65, 300));
		return CFG_W'($urandom_range(MAX_DELAY + 1, 65535));
	endfunction

	function logic [CFG_W-1:0] pick_wet();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return MIX_ONE;
		if (r < 40)
			return CFG_W'($urandom_range(32769, 65535));
		return CFG_W'($urandom_range(0, 32768));
	endfunction

	// offer one item, hold it until the block takes it
	task automatic send_item(smp_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		sample_in <= s;
		do
			@(posedge clk);
		while (full);
		sb.take_sample(s);
	endtask

	// sender pauses until every expected result is back, then lets the pipe drain
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// register writes only happen on an idle block
	task automatic set_regs(bit do_delay, logic [CFG_W-1:0] d, bit do_wet,
		logic [CFG_W-1:0] w);
		settle();
		if (do_delay) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_DELAY;
			cfg_data  <= d;
			@(posedge clk);
			sb.write_reg(CFG_DELAY, d);
		end
		if (do_wet) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_WET;
			cfg_data  <= w;
			@(posedge clk);
			sb.write_reg(CFG_WET, w);
		end
		cfg_we <= 1'b0;
	endtask

	// receiver: checks every popped item, stalls at random and once for a long stretch
	initial begin
		int hold_left;
		bit big_hold_done;
		int r;
		hold_left     = 0;
		big_hold_done = 1'b0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_sample_out(sample_out);
				results_seen++;
			end
			if (!big_hold_done && results_seen >= HOLD_AT) begin
				// sender keeps offering meanwhile, so the block fills and raises full
				big_hold_done = 1'b1;
				hold_left     = BIG_HOLD;
			end else if (hold_left == 0 && !steady) begin
				r = $urandom_range(0, 99);
				if (r < 20)
					hold_left = $urandom_range(1, 3);
				else if (r < 23)
					hold_left = $urandom_range(8, 40);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog: too long without any handshake means the block is stuck
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** audio_delay_wet_dry_mix_unit: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		int sent;
		int n;
		int unsigned len;
		bit do_delay;
		logic [CFG_W-1:0] d;
		logic [CFG_W-1:0] w;

		arst_n    <= 1'b0;
		push      <= 1'b0;
		sample_in <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_DELAY;
		cfg_data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: longest delay, half wet, history reads as zeros
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'h8000));
		send_item(smp_t'(16'hffff));

		// one-sample delay, fully wet: output is the previous sample
		set_regs(1'b1, CFG_W'(1), 1'b1, MIX_ONE);
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'h8000));
		send_item(smp_t'(16'h0000));
		send_item(smp_t'(16'h0001));

		// zero delay acts as one, mix above one acts as fully wet
		set_regs(1'b1, '0, 1'b1, '1);
		send_item(smp_t'(16'h8000));
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'hffff));

		// delay code past the store size clamps, fully dry
		set_regs(1'b1, '1, 1'b1, '0);
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'h8000));

		// short ring, half mix: negative blends round toward minus infinity
		set_regs(1'b1, CFG_W'(3), 1'b1, MIX_RST);
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'h8000));
		send_item(smp_t'(16'h8000));
		send_item(smp_t'(16'hffff));
		send_item(smp_t'(16'h0001));
		send_item(smp_t'(16'h8000));

		// mix change alone keeps the history
		set_regs(1'b0, '0, 1'b1, CFG_W'(1));
		send_item(smp_t'(16'h7fff));
		send_item(smp_t'(16'h8000));
		send_item(smp_t'(16'd12345));

		// one full lap of a mid-size ring, past the point where the lap flag flips
		set_regs(1'b1, CFG_W'(LAP_LEN), 1'b1, CFG_W'(24576));
		repeat (LAP_ITEMS) send_item(rand_sample());

		// random phases, each with its own settings
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			do_delay = ($urandom_range(0, 4) != 0);
			d = pick_delay();
			w = pick_wet();
			set_regs(do_delay, d, 1'b1, w);
			len = sb.effective_len();
			n = $urandom_range(8, 40);
			// make short rings wrap at least once
			if (len <= 300)
				n += len;
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			steady = ($urandom_range(0, 3) == 0);
			repeat (n) send_item(rand_sample());
			sent += n;
		end
		steady = 1'b0;

		// drain, then a few more cycles to catch any stray result
		settle();
		if (sb.errors == 0)
			$display("** audio_delay_wet_dry_mix_unit: PASSED **");
		else
			$display("** audio_delay_wet_dry_mix_unit: FAILED **");
		$finish;
	end

endmodule
